@@ rtl/slmd_pkg.sv @@
package slmd_pkg;

  localparam int LIST_DEPTH_DEF  = 32;
  localparam int ENTITY_BITS_DEF = 10;

  // Fixed widths of the result fields and list counters.
  localparam int OP_W   = 3;
  localparam int SLOT_W = 5;
  localparam int CNT_W  = 6;

  // Entries in the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [OP_W-1:0] {
    OP_UPDATE = 3'd0,
    OP_ADD    = 3'd1,
    OP_REMOVE = 3'd2,
    OP_END    = 3'd3,
    OP_ERROR  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ITEM,
    ST_TAIL
  } state_t;

  // Classification of one request, made by the front part.
  typedef struct packed {
    logic has;    // request carries an entity
    logic bad;    // entity is rejected (order, reserved number or list full)
    logic close;  // request ends the frame
    logic clear;  // drop the old list before merging
  } item_ctl_t;

endpackage

@@ rtl/slmd_front.sv @@
module slmd_front #(
  parameter int LIST_DEPTH  = slmd_pkg::LIST_DEPTH_DEF,
  parameter int ENTITY_BITS = slmd_pkg::ENTITY_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic [ENTITY_BITS-1:0] entity_number,
  input  logic                   has_entity,
  input  logic                   frame_last,
  input  logic                   no_reference,
  output slmd_pkg::item_ctl_t    ctl
);

  localparam logic [ENTITY_BITS:0] PREV_NONE = '1;

  logic [ENTITY_BITS:0]          prev_r, prev_nxt;
  logic [slmd_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                          first;

  // The front keeps its own copy of the frame progress, so it can judge
  // each request the moment it arrives.
  always_comb begin
    first     = (prev_r == PREV_NONE);
    ctl.has   = has_entity;
    ctl.close = !has_entity || frame_last;
    ctl.clear = first && no_reference;
    ctl.bad   = has_entity &&
                ((entity_number == '1) ||
                 (!first && ({1'b0, entity_number} <= prev_r)) ||
                 (cnt_r >= slmd_pkg::CNT_W'(LIST_DEPTH)));
    prev_nxt = prev_r;
    cnt_nxt  = cnt_r;
    if (accept) begin
      if (has_entity && !ctl.bad) begin
        prev_nxt = {1'b0, entity_number};
        cnt_nxt  = cnt_r + 1'b1;
      end
      if (ctl.close) begin
        prev_nxt = PREV_NONE;
        cnt_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= PREV_NONE;
      cnt_r  <= '0;
    end else begin
      prev_r <= prev_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

@@ rtl/slmd_queue.sv @@
module slmd_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             empty,
  output logic             full
);

  localparam int DEPTH = slmd_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]      fill_r, fill_nxt;

  always_comb begin
    empty      = (fill_r == '0);
    full       = (fill_r == (PW + 1)'(DEPTH));
    head_data  = slot_r[rd_ptr_r];
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop)) else $error("queue overflow");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("queue underflow");

endmodule

@@ rtl/slmd_back.sv @@
module slmd_back #(
  parameter int LIST_DEPTH  = slmd_pkg::LIST_DEPTH_DEF,
  parameter int ENTITY_BITS = slmd_pkg::ENTITY_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  slmd_pkg::item_ctl_t         q_ctl,
  input  logic [ENTITY_BITS-1:0]      q_ent,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [slmd_pkg::OP_W-1:0]   out_op,
  output logic [ENTITY_BITS-1:0]      out_ent_number,
  output logic [slmd_pkg::SLOT_W-1:0] out_old_slot,
  output logic [slmd_pkg::SLOT_W-1:0] out_new_slot,
  output logic                        out_run_last
);

  localparam int MEM_DEPTH = 2 * LIST_DEPTH;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam logic [AW-1:0] BANK_OFS = AW'(LIST_DEPTH);
  localparam int CW = slmd_pkg::CNT_W;
  localparam int SW = slmd_pkg::SLOT_W;

  logic [ENTITY_BITS-1:0] mem [MEM_DEPTH];

  slmd_pkg::state_t       state_r, state_nxt;
  slmd_pkg::item_ctl_t    cur_ctl_r, cur_ctl_nxt;
  logic [ENTITY_BITS-1:0] cur_ent_r, cur_ent_nxt;
  logic                   bank_r, bank_nxt;
  logic [CW-1:0]          old_cnt_r, old_cnt_nxt;
  logic [CW-1:0]          new_cnt_r, new_cnt_nxt;
  logic [CW-1:0]          old_ptr_r, old_ptr_nxt;
  logic [ENTITY_BITS-1:0] rd_data_r;
  logic [AW-1:0]          rd_addr, wr_addr;
  logic                   wr_en;

  logic                   out_valid_r, out_valid_nxt;
  slmd_pkg::op_t          out_op_r, out_op_nxt;
  logic [ENTITY_BITS-1:0] out_ent_r, out_ent_nxt;
  logic [SW-1:0]          out_os_r, out_os_nxt;
  logic [SW-1:0]          out_ns_r, out_ns_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   can_emit, emit, old_avail, hit;
  slmd_pkg::op_t          e_op;
  logic [ENTITY_BITS-1:0] e_ent;
  logic [SW-1:0]          e_os, e_ns;
  logic                   e_last;

  always_comb begin
    state_nxt   = state_r;
    cur_ctl_nxt = cur_ctl_r;
    cur_ent_nxt = cur_ent_r;
    bank_nxt    = bank_r;
    old_cnt_nxt = old_cnt_r;
    new_cnt_nxt = new_cnt_r;
    old_ptr_nxt = old_ptr_r;
    q_pop       = 1'b0;
    wr_en       = 1'b0;
    emit        = 1'b0;
    e_op        = slmd_pkg::OP_END;
    e_ent       = '1;
    e_os        = '0;
    e_ns        = '0;
    e_last      = 1'b0;
    can_emit    = !out_valid_r || !out_stall;
    old_avail   = (old_ptr_r < old_cnt_r);
    hit         = old_avail && (rd_data_r == cur_ent_r);

    case (state_r)
      slmd_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop       = 1'b1;
          cur_ctl_nxt = q_ctl;
          cur_ent_nxt = q_ent;
          if (q_ctl.clear) begin
            old_cnt_nxt = '0;
            old_ptr_nxt = '0;
          end
          state_nxt = slmd_pkg::ST_ITEM;
        end
      end
      slmd_pkg::ST_ITEM: begin
        if (!cur_ctl_r.has) begin
          state_nxt = slmd_pkg::ST_TAIL;
        end else if (can_emit) begin
          emit = 1'b1;
          if (cur_ctl_r.bad) begin
            e_op      = slmd_pkg::OP_ERROR;
            e_ent     = cur_ent_r;
            e_last    = !cur_ctl_r.close;
            state_nxt = cur_ctl_r.close ? slmd_pkg::ST_TAIL : slmd_pkg::ST_IDLE;
          end else if (old_avail && (rd_data_r < cur_ent_r)) begin
            e_op        = slmd_pkg::OP_REMOVE;
            e_ent       = rd_data_r;
            e_os        = old_ptr_r[SW-1:0];
            old_ptr_nxt = old_ptr_r + 1'b1;
          end else begin
            e_op  = hit ? slmd_pkg::OP_UPDATE : slmd_pkg::OP_ADD;
            e_ent = cur_ent_r;
            e_os  = hit ? old_ptr_r[SW-1:0] : '0;
            e_ns  = new_cnt_r[SW-1:0];
            if (hit) begin
              old_ptr_nxt = old_ptr_r + 1'b1;
            end
            wr_en       = 1'b1;
            new_cnt_nxt = new_cnt_r + 1'b1;
            e_last      = !cur_ctl_r.close;
            state_nxt   = cur_ctl_r.close ? slmd_pkg::ST_TAIL : slmd_pkg::ST_IDLE;
          end
        end
      end
      slmd_pkg::ST_TAIL: begin
        if (can_emit) begin
          emit = 1'b1;
          if (old_avail) begin
            e_op        = slmd_pkg::OP_REMOVE;
            e_ent       = rd_data_r;
            e_os        = old_ptr_r[SW-1:0];
            old_ptr_nxt = old_ptr_r + 1'b1;
          end else begin
            // End of frame: the new list becomes the old one.
            e_last      = 1'b1;
            bank_nxt    = !bank_r;
            old_cnt_nxt = new_cnt_r;
            new_cnt_nxt = '0;
            old_ptr_nxt = '0;
            state_nxt   = slmd_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = slmd_pkg::ST_IDLE;
      end
    endcase

    // The read address follows the next pointer, so the registered read
    // data always matches the pointer held in the current cycle.
    rd_addr = (bank_nxt ? BANK_OFS : '0) + AW'(old_ptr_nxt);
    wr_addr = (bank_r ? '0 : BANK_OFS) + AW'(new_cnt_r);

    out_valid_nxt = out_valid_r;
    out_op_nxt    = out_op_r;
    out_ent_nxt   = out_ent_r;
    out_os_nxt    = out_os_r;
    out_ns_nxt    = out_ns_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_op_nxt    = e_op;
      out_ent_nxt   = e_ent;
      out_os_nxt    = e_os;
      out_ns_nxt    = e_ns;
      out_last_nxt  = e_last;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= slmd_pkg::ST_IDLE;
      bank_r      <= 1'b0;
      old_cnt_r   <= '0;
      new_cnt_r   <= '0;
      old_ptr_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bank_r      <= bank_nxt;
      old_cnt_r   <= old_cnt_nxt;
      new_cnt_r   <= new_cnt_nxt;
      old_ptr_r   <= old_ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_ctl_r  <= cur_ctl_nxt;
    cur_ent_r  <= cur_ent_nxt;
    out_op_r   <= out_op_nxt;
    out_ent_r  <= out_ent_nxt;
    out_os_r   <= out_os_nxt;
    out_ns_r   <= out_ns_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= cur_ent_r;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_valid      = out_valid_r;
  assign out_op         = out_op_r;
  assign out_ent_number = out_ent_r;
  assign out_old_slot   = out_os_r;
  assign out_new_slot   = out_ns_r;
  assign out_run_last   = out_last_r;

  a_ptr_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    old_ptr_r <= old_cnt_r) else $error("old pointer beyond old list");

  a_new_list_bound: assert property (@(posedge clk) disable iff (!rst_n)
    new_cnt_r <= CW'(LIST_DEPTH)) else $error("new list overflow");

  a_no_write_on_swap: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (bank_nxt == bank_r)) else $error("list write during bank swap");

  a_pop_starts_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == slmd_pkg::ST_ITEM)) else $error("pop without item");

endmodule

@@ rtl/sorted_list_delta_merge_top.sv @@
// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_stall   entity_number, has_entity, frame_last,
//                                            no_reference
// out_      output     out_valid / out_stall op, ent_number, old_slot, new_slot, run_last
//
// In the merge engine a request is popped from the queue; a rejected one then gives its
// error result, any other gives a remove for each old entry below it and then its update
// or add result. Closing a frame gives a remove for each remaining old entry and then the
// end marker. The list's single read port walks one old entry per cycle unless stalled.
// Synchronous active-low reset empties both lists and the request queue; the list
// memory itself is not cleared, since only written entries are ever read.
// in_stall rises only when the two-entry request queue is full; out_stall freezes the
// merge engine without touching the queue, so requests keep flowing in until it fills.
module sorted_list_delta_merge_top #(
  parameter int LIST_DEPTH  = slmd_pkg::LIST_DEPTH_DEF,
  parameter int ENTITY_BITS = slmd_pkg::ENTITY_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ENTITY_BITS-1:0]      in_entity_number,
  input  logic                        in_has_entity,
  input  logic                        in_frame_last,
  input  logic                        in_no_reference,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [slmd_pkg::OP_W-1:0]   out_op,
  output logic [ENTITY_BITS-1:0]      out_ent_number,
  output logic [slmd_pkg::SLOT_W-1:0] out_old_slot,
  output logic [slmd_pkg::SLOT_W-1:0] out_new_slot,
  output logic                        out_run_last
);

  localparam int CTL_W = $bits(slmd_pkg::item_ctl_t);
  localparam int Q_W   = CTL_W + ENTITY_BITS;

  logic                   in_accept;
  logic                   q_full, q_empty, q_pop;
  slmd_pkg::item_ctl_t    f_ctl, q_ctl;
  logic [Q_W-1:0]         q_head;
  logic [ENTITY_BITS-1:0] q_ent;

  // A request is taken whenever the queue has room; the front part judges it
  // against its own copy of the frame progress as it goes in.
  assign in_stall  = q_full;
  assign in_accept = in_valid && !q_full;

  slmd_front #(
    .LIST_DEPTH  (LIST_DEPTH),
    .ENTITY_BITS (ENTITY_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (in_accept),
    .entity_number (in_entity_number),
    .has_entity    (in_has_entity),
    .frame_last    (in_frame_last),
    .no_reference  (in_no_reference),
    .ctl           (f_ctl)
  );

  // The queue decouples request intake from the merge walk, which may emit many
  // results for one request.
  slmd_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_data ({f_ctl, in_entity_number}),
    .pop       (q_pop),
    .head_data (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  assign q_ctl = slmd_pkg::item_ctl_t'(q_head[Q_W-1:ENTITY_BITS]);
  assign q_ent = q_head[ENTITY_BITS-1:0];

  // The back part holds both list banks; unstalled, it gives up to one result per cycle.
  slmd_back #(
    .LIST_DEPTH  (LIST_DEPTH),
    .ENTITY_BITS (ENTITY_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_ctl          (q_ctl),
    .q_ent          (q_ent),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_op         (out_op),
    .out_ent_number (out_ent_number),
    .out_old_slot   (out_old_slot),
    .out_new_slot   (out_new_slot),
    .out_run_last   (out_run_last)
  );

endmodule

@@ test/tb_sorted_list_delta_merge_top.sv @@
module tb_sorted_list_delta_merge_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENT_W    = slmd_pkg::ENTITY_BITS_DEF;
  localparam int LIST_LEN = slmd_pkg::LIST_DEPTH_DEF;

  // All ones is reserved: it marks the end of the list on the result side.
  localparam logic [ENT_W-1:0] ENT_RESERVED = {ENT_W{1'b1}};
  // The frame-start marker is one bit wider than an entity number.
  localparam logic [ENT_W:0]   PREV_NONE    = {(ENT_W + 1){1'b1}};

  // The random part stops once this many requests have gone in after the directed table.
  localparam int unsigned RANDOM_REQUESTS = 200;
  // Cycle limit for the whole run, set with a wide margin above the slowest legal run.
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned LONG_HOLD       = 80;
  localparam int unsigned TAIL_CYCLES     = 40;

  typedef struct packed {
    slmd_pkg::op_t    op;
    logic [ENT_W-1:0] ent;
    logic [4:0]       old_slot;
    logic [4:0]       new_slot;
    logic             run_last;
  } merge_result_t;

  // One request of the stimulus. When "typed" is set, the result is written into the
  // row by hand and replaces what the list predictor works out.
  typedef struct {
    logic [ENT_W-1:0] ent;
    bit               has;
    bit               last;
    bit               noref;
    bit               typed;
    merge_result_t    want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [ENT_W-1:0] in_entity_number = '0;
  logic             in_has_entity = 1'b0;
  logic             in_frame_last = 1'b0;
  logic             in_no_reference = 1'b0;

  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [slmd_pkg::OP_W-1:0]   out_op;
  logic [ENT_W-1:0] out_ent_number;
  logic [slmd_pkg::SLOT_W-1:0] out_old_slot;
  logic [slmd_pkg::SLOT_W-1:0] out_new_slot;
  logic             out_run_last;

  // Travels with the request on the input side, so the checker knows at acceptance
  // whether the current request carries a hand-written result.
  bit               row_typed = 1'b0;
  merge_result_t    row_want = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sorted_list_delta_merge_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_entity_number (in_entity_number),
    .in_has_entity    (in_has_entity),
    .in_frame_last    (in_frame_last),
    .in_no_reference  (in_no_reference),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_op           (out_op),
    .out_ent_number   (out_ent_number),
    .out_old_slot     (out_old_slot),
    .out_new_slot     (out_new_slot),
    .out_run_last     (out_run_last)
  );

  // ---------------------------------------------------------------------------
  // List predictor. It keeps its own two banks of the list memory: one holds the
  // list of the previous frame (old list) and the other collects the current frame.
  // ---------------------------------------------------------------------------
  logic [ENT_W-1:0] ref_list [0:2*LIST_LEN-1];
  bit               ref_bank = 1'b0;
  int unsigned      ref_old_cnt = 0;
  int unsigned      ref_new_cnt = 0;
  int unsigned      ref_old_ptr = 0;
  logic [ENT_W:0]   ref_prev = PREV_NONE;

  merge_result_t    step_q[$];      // results of the request being predicted
  merge_result_t    expected_q[$];  // results still owed by the block, oldest first

  int unsigned      err_count = 0;
  int unsigned      items_sent = 0;
  int unsigned      cycle_count = 0;
  bit               no_idle = 1'b0;
  bit               hold_off_pending = 1'b0;
  int unsigned      prev_frame_q[$];

  function automatic logic [ENT_W-1:0] old_entry_at(input int unsigned pos);
    return ref_list[(ref_bank ? LIST_LEN : 0) + pos];
  endfunction

  function automatic void add_result(input slmd_pkg::op_t op,
                                     input logic [ENT_W-1:0] ent,
                                     input int unsigned old_slot,
                                     input int unsigned new_slot);
    merge_result_t res;
    res.op       = op;
    res.ent      = ent;
    res.old_slot = old_slot[4:0];
    res.new_slot = new_slot[4:0];
    res.run_last = 1'b0;
    step_q.push_back(res);
  endfunction

  // Merges one request against the old list and leaves its results in step_q.
  function automatic void merge_request(input logic [ENT_W-1:0] ent, input bit has,
                                        input bit last, input bit noref);
    bit first;
    bit bad;
    step_q.delete();
    first = (ref_prev == PREV_NONE);

    // The old list is dropped at frame start even if this request is then rejected.
    if (first && noref) begin
      ref_old_cnt = 0;
      ref_old_ptr = 0;
    end

    if (has) begin
      bad = (ent == ENT_RESERVED) || (!first && {1'b0, ent} <= ref_prev)
            || (ref_new_cnt >= LIST_LEN);
      if (bad) begin
        add_result(slmd_pkg::OP_ERROR, ent, 0, 0);
      end else begin
        // Old entries below the new number are gone from this frame.
        while (ref_old_ptr < ref_old_cnt && old_entry_at(ref_old_ptr) < ent) begin
          add_result(slmd_pkg::OP_REMOVE, old_entry_at(ref_old_ptr), ref_old_ptr, 0);
          ref_old_ptr++;
        end
        if (ref_old_ptr < ref_old_cnt && old_entry_at(ref_old_ptr) == ent) begin
          add_result(slmd_pkg::OP_UPDATE, ent, ref_old_ptr, ref_new_cnt);
          ref_old_ptr++;
        end else begin
          add_result(slmd_pkg::OP_ADD, ent, 0, ref_new_cnt);
        end
        ref_list[(ref_bank ? 0 : LIST_LEN) + ref_new_cnt] = ent;
        ref_new_cnt++;
        ref_prev = {1'b0, ent};
      end
    end

    // An empty request closes the frame whether or not frame_last is set.
    if (!has || last) begin
      while (ref_old_ptr < ref_old_cnt) begin
        add_result(slmd_pkg::OP_REMOVE, old_entry_at(ref_old_ptr), ref_old_ptr, 0);
        ref_old_ptr++;
      end
      add_result(slmd_pkg::OP_END, ENT_RESERVED, 0, 0);
      ref_bank    = ~ref_bank;
      ref_old_cnt = ref_new_cnt;
      ref_new_cnt = 0;
      ref_old_ptr = 0;
      ref_prev    = PREV_NONE;
    end

    // Every request causes at least one result.
    step_q[step_q.size()-1].run_last = 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Checker. Both handshakes are sampled at the rising edge, before any update of
  // that edge lands. The result side is checked first and the new request predicted
  // after it, in one process, so the order of events inside a time step never
  // matters. A request passes through the queue and the engine's state before its results
  // are registered, so they can never show up at the edge where it is accepted.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    merge_result_t got;
    merge_result_t want;
    if (rst_n === 1'b1) begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        got.op       = slmd_pkg::op_t'(out_op);
        got.ent      = out_ent_number;
        got.old_slot = out_old_slot;
        got.new_slot = out_new_slot;
        got.run_last = out_run_last;
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result op %0d ent %0d old %0d new %0d last %0d",
                                    got.op, got.ent, got.old_slot, got.new_slot,
                                    got.run_last));
        end else begin
          want = expected_q.pop_front();
          if (got.op !== want.op || got.ent !== want.ent || got.old_slot !== want.old_slot
              || got.new_slot !== want.new_slot || got.run_last !== want.run_last) begin
            report_mismatch($sformatf({"got op %0d ent %0d old %0d new %0d last %0d, ",
                                       "want op %0d ent %0d old %0d new %0d last %0d"},
                                      got.op, got.ent, got.old_slot, got.new_slot,
                                      got.run_last, want.op, want.ent, want.old_slot,
                                      want.new_slot, want.run_last));
          end
        end
      end

      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        // The predictor always runs so that its lists stay in step with the block,
        // even when the row supplies its own result.
        merge_request(in_entity_number, in_has_entity, in_frame_last, in_no_reference);
        if (row_typed) begin
          expected_q.push_back(row_want);
        end else begin
          foreach (step_q[k]) expected_q.push_back(step_q[k]);
        end
      end
    end
  end

  // A hung block ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[sorted_list_delta_merge_top] ERROR");
      $finish;
    end
  end

  // Gap length for either side: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 9);
    return $urandom_range(15, 24);
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver. It stalls the result channel at random. On request from the main
  // sequence it holds off for a long stretch, counted here, so the request queue
  // fills up and the block has to stall its input.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned n;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        n = pick_gap();
        if (n != 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender. A request is put on the channel at a rising edge and held until the
  // edge at which in_stall is seen low. When the next request follows without a gap,
  // in_valid simply stays high and only the payload changes.
  // ---------------------------------------------------------------------------
  task automatic send_request(input stim_row_t r);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_entity_number <= r.ent;
    in_has_entity    <= r.has;
    in_frame_last    <= r.last;
    in_no_reference  <= r.noref;
    row_typed        <= r.typed;
    row_want         <= r.want;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    items_sent++;
  endtask

  // Pauses the sender until every owed result has come back. The first edge lets the
  // checker take in the request accepted at the current edge.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic stim_row_t plain_row(input logic [ENT_W-1:0] ent, input bit has,
                                          input bit last, input bit noref);
    stim_row_t r;
    r.ent   = ent;
    r.has   = has;
    r.last  = last;
    r.noref = noref;
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  // Rows whose single result is obvious; slots other than new_slot are zero there.
  stim_row_t dir_rows[$];

  function automatic void add_typed(input logic [ENT_W-1:0] ent, input bit has,
                                    input bit last, input bit noref,
                                    input slmd_pkg::op_t op,
                                    input logic [ENT_W-1:0] res_ent,
                                    input int unsigned new_slot);
    stim_row_t r;
    r = plain_row(ent, has, last, noref);
    r.typed         = 1'b1;
    r.want.op       = op;
    r.want.ent      = res_ent;
    r.want.old_slot = '0;
    r.want.new_slot = new_slot[4:0];
    r.want.run_last = 1'b1;
    dir_rows.push_back(r);
  endfunction

  // A number that the block has to reject: the reserved number, or one not above the
  // previous number of the frame.
  function automatic logic [ENT_W-1:0] bad_number(input int unsigned ceiling,
                                                  input bit have_prev);
    if (!have_prev || $urandom_range(0, 3) == 0) return ENT_RESERVED;
    return ENT_W'($urandom_range(0, ceiling));
  endfunction

  // One random frame: an ascending run that keeps part of the previous frame (so
  // updates happen) and adds fresh numbers, with rejected requests mixed in now and
  // then. The frame closes on the last entity, on an empty request, or on a rejected
  // request that carries frame_last.
  task automatic run_frame(input int unsigned n_ent);
    bit          pick [0:1022];
    int unsigned vals[$];
    int unsigned count;
    int unsigned k;
    int unsigned close_mode;
    int unsigned r;
    bit          is_last;
    foreach (pick[j]) pick[j] = 1'b0;
    count = 0;
    foreach (prev_frame_q[j]) begin
      if (count < n_ent && $urandom_range(0, 99) < 60 && !pick[prev_frame_q[j]]) begin
        pick[prev_frame_q[j]] = 1'b1;
        count++;
      end
    end
    while (count < n_ent) begin
      k = $urandom_range(0, 1022);
      if (!pick[k]) begin
        pick[k] = 1'b1;
        count++;
      end
    end
    foreach (pick[j]) if (pick[j]) vals.push_back(j);

    r = $urandom_range(0, 99);
    if (n_ent == 0) close_mode = (r < 70) ? 1 : 2;
    else close_mode = (r < 60) ? 0 : (r < 85) ? 1 : 2;

    for (int i = 0; i < vals.size(); i++) begin
      if ($urandom_range(0, 99) < 8) begin
        send_request(plain_row(bad_number(i > 0 ? vals[i-1] : 0, i > 0), 1'b1, 1'b0,
                               $urandom_range(0, 6) == 0));
      end
      is_last = (close_mode == 0) && (i == vals.size() - 1);
      send_request(plain_row(ENT_W'(vals[i]), 1'b1, is_last,
                             $urandom_range(0, 6) == 0));
    end

    if (close_mode == 1) begin
      send_request(plain_row(ENT_W'($urandom_range(0, 1023)), 1'b0,
                             $urandom_range(0, 1) == 1, $urandom_range(0, 6) == 0));
    end else if (close_mode == 2) begin
      send_request(plain_row(bad_number(vals.size() > 0 ? vals[vals.size()-1] : 0,
                                        vals.size() > 0),
                             1'b1, 1'b1, $urandom_range(0, 6) == 0));
    end

    prev_frame_q.delete();
    foreach (vals[j]) if (j < LIST_LEN) prev_frame_q.push_back(vals[j]);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence: reset, the directed table, then random frames.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned frame_no;
    int unsigned n_ent;
    int unsigned r;
    int unsigned start_count;

    // Frame 1 from an empty list: lowest number, a repeat, the reserved number, the
    // highest legal number closing the frame.
    add_typed(10'd0, 1'b1, 1'b0, 1'b0, slmd_pkg::OP_ADD, 10'd0, 0);
    add_typed(10'd0, 1'b1, 1'b0, 1'b0, slmd_pkg::OP_ERROR, 10'd0, 0);
    add_typed(ENT_RESERVED, 1'b1, 1'b0, 1'b0, slmd_pkg::OP_ERROR, ENT_RESERVED, 0);
    add_typed(10'd5, 1'b1, 1'b0, 1'b0, slmd_pkg::OP_ADD, 10'd5, 1);
    dir_rows.push_back(plain_row(10'd1022, 1'b1, 1'b1, 1'b0));
    // Frame 2: remove, update, add, a repeat, then a lower number on the last item
    // that is rejected but still closes the frame.
    dir_rows.push_back(plain_row(10'd5, 1'b1, 1'b0, 1'b0));
    dir_rows.push_back(plain_row(10'd700, 1'b1, 1'b0, 1'b0));
    add_typed(10'd700, 1'b1, 1'b0, 1'b0, slmd_pkg::OP_ERROR, 10'd700, 0);
    dir_rows.push_back(plain_row(10'd600, 1'b1, 1'b1, 1'b0));
    // An empty request without frame_last closes the frame and removes everything.
    dir_rows.push_back(plain_row(10'd300, 1'b0, 1'b0, 1'b0));
    // An empty frame against an empty list gives only the end marker.
    add_typed(10'd0, 1'b0, 1'b1, 1'b0, slmd_pkg::OP_END, ENT_RESERVED, 0);
    add_typed(10'd10, 1'b1, 1'b0, 1'b0, slmd_pkg::OP_ADD, 10'd10, 0);
    dir_rows.push_back(plain_row(10'd20, 1'b1, 1'b1, 1'b0));
    // Dropping the reference on a request that is itself rejected still clears the
    // old list, so the next number is an add at slot zero.
    add_typed(ENT_RESERVED, 1'b1, 1'b0, 1'b1, slmd_pkg::OP_ERROR, ENT_RESERVED, 0);
    add_typed(10'd20, 1'b1, 1'b0, 1'b0, slmd_pkg::OP_ADD, 10'd20, 0);
    dir_rows.push_back(plain_row(10'd30, 1'b1, 1'b1, 1'b0));
    // No reference on an empty request: nothing left to remove.
    add_typed(10'd1023, 1'b0, 1'b1, 1'b1, slmd_pkg::OP_END, ENT_RESERVED, 0);
    dir_rows.push_back(plain_row(10'd1022, 1'b1, 1'b1, 1'b0));
    // Mid-frame no_reference is ignored, so the highest number is an update.
    add_typed(10'd0, 1'b1, 1'b0, 1'b0, slmd_pkg::OP_ADD, 10'd0, 0);
    dir_rows.push_back(plain_row(10'd1022, 1'b1, 1'b1, 1'b1));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_request(dir_rows[i]);
    wait_for_drain();

    // Frame 1 comes with a long receiver hold-off, frame 3 overfills the new list
    // (the extra entities are rejected) and the frame after it removes most of it.
    // Frame 6 ends with the sender waiting for the block to drain, and frames 8 to 10
    // run without idling on either side.
    frame_no = 0;
    start_count = items_sent;
    while (items_sent - start_count < RANDOM_REQUESTS) begin
      no_idle = (frame_no >= 8 && frame_no <= 10);
      if (frame_no == 1) hold_off_pending = 1'b1;
      r = $urandom_range(0, 99);
      if (frame_no == 1) n_ent = 12;
      else if (frame_no == 3) n_ent = 35;
      else if (r < 70) n_ent = $urandom_range(0, 6);
      else if (r < 92) n_ent = $urandom_range(7, 20);
      else n_ent = $urandom_range(28, 36);
      run_frame(n_ent);
      if (frame_no == 6) wait_for_drain();
      frame_no++;
    end
    no_idle = 1'b0;

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("[sorted_list_delta_merge_top] OK");
    end else begin
      $display("[sorted_list_delta_merge_top] ERROR");
    end
    $finish;
  end

endmodule
